@@ src/assert_macros.svh @@
// Assertion helpers shared by the tokenizer modules.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked out of reset.
`define ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("%m: same-cycle check failed");

// Next-cycle implication, checked out of reset.
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("%m: next-cycle check failed");

`endif

@@ src/cst_pkg.sv @@
package cst_pkg;

	localparam int POS_BITS = 16;
	localparam int POS_W    = POS_BITS;
	localparam int END_W    = POS_BITS + 1;
	localparam int MAX_RES  = 4;

	localparam logic [END_W-1:0] POS_LIM = {1'b1, {POS_BITS{1'b0}}};
	localparam logic [END_W-1:0] POS_SAT = POS_LIM + END_W'(1);

	localparam logic [7:0] CH_SLASH = 8'h2F;
	localparam logic [7:0] CH_STAR  = 8'h2A;
	localparam logic [7:0] CH_NL    = 8'h0A;
	localparam logic [7:0] CH_NUL   = 8'h00;

	localparam logic KIND_TOKEN = 1'b0;
	localparam logic KIND_EOT   = 1'b1;

	typedef struct packed {
		logic             kind;
		logic [POS_W-1:0] tstart;
		logic [END_W-1:0] tend;
		logic             ovf;
	} cst_res_t;

	typedef struct packed {
		logic [2:0]               n;
		cst_res_t [MAX_RES-1:0]   res;
	} cst_bundle_t;

endpackage

@@ src/cst_in_reg.sv @@
module cst_in_reg
	import cst_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       byte_valid,
	output logic       byte_stall,
	input  logic [7:0] ch,
	input  logic       final_byte,
	input  logic       adv,
	output logic       vld_s1,
	output logic [7:0] ch_s1,
	output logic       fin_s1
);

	logic take_in;

	assign byte_stall = vld_s1 && !adv;
	assign take_in    = byte_valid && !byte_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (take_in) begin
			vld_s1 <= 1'b1;
		end else if (adv) begin
			vld_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (take_in) begin
			ch_s1  <= ch;
			fin_s1 <= final_byte;
		end
	end

endmodule

@@ src/cst_core.sv @@
`include "assert_macros.svh"

module cst_core
	import cst_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        vld_s1,
	input  logic [7:0]  ch_s1,
	input  logic        fin_s1,
	input  logic        take,
	output logic        adv,
	output logic        load,
	output cst_bundle_t bnd
);

	typedef struct packed {
		logic [7:0]       prior;
		logic             in_tok;
		logic [POS_W-1:0] ostart;
		logic             line;
		logic             block;
	} scan_t;

	typedef struct packed {
		scan_t            st;
		logic             skip;
		logic             emit;
		logic [POS_W-1:0] estart;
		logic [END_W-1:0] eend;
	} exam_t;

	function automatic logic is_space(logic [7:0] c);
		return (c == 8'h20) || (c >= 8'h09 && c <= 8'h0D);
	endfunction

	function automatic logic is_alnum(logic [7:0] c);
		return (c >= 8'h30 && c <= 8'h39) || (c >= 8'h41 && c <= 8'h5A) ||
			(c >= 8'h61 && c <= 8'h7A);
	endfunction

	function automatic logic [POS_W-1:0] to_start(logic [END_W-1:0] i);
		return (i >= POS_LIM) ? {POS_W{1'b1}} : i[POS_W-1:0];
	endfunction

	function automatic exam_t examine(scan_t st, logic [7:0] c, logic [7:0] nx,
		logic [END_W-1:0] idx);
		exam_t r;
		r.st     = st;
		r.skip   = 1'b0;
		r.emit   = 1'b0;
		r.estart = st.ostart;
		r.eend   = idx;
		if (!r.st.line && !r.st.block && c == CH_SLASH && nx == CH_STAR) begin
			r.st.block = 1'b1;
			r.skip     = 1'b1;
		end
		if (!r.st.line && !r.st.block && c == CH_SLASH && nx == CH_SLASH) begin
			r.st.line = 1'b1;
			r.skip    = 1'b1;
		end
		// an opening comment closes the open token
		if ((r.st.block || r.st.line) && r.st.in_tok) begin
			r.st.in_tok = 1'b0;
			r.emit      = 1'b1;
		end
		if (r.st.block) begin
			if (c == CH_STAR && nx == CH_SLASH) begin
				r.st.block = 1'b0;
				r.skip     = 1'b1;
			end
		end else if (r.st.line) begin
			if (c == CH_NL) begin
				r.st.line = 1'b0;
			end
		end
		if (!r.skip && !r.st.block && !r.st.line) begin
			if (r.st.in_tok && (is_space(c) || !is_alnum(r.st.prior) || !is_alnum(c))) begin
				r.st.in_tok = 1'b0;
				r.emit      = 1'b1;
			end
			if (!r.st.in_tok && !is_space(c)) begin
				r.st.in_tok = 1'b1;
				r.st.ostart = to_start(idx);
			end
		end
		r.st.prior = c;
		return r;
	endfunction

	logic [7:0]       held_q;
	logic             held_vld_q;
	logic             drop_q;
	scan_t            st_q;
	logic [END_W-1:0] pos_q;
	logic             ovf_q;

	logic [END_W-1:0] cur;
	logic [END_W-1:0] pos_n;
	logic [END_W-1:0] len;
	logic [END_W-1:0] hidx;
	logic             ovf_n;
	logic             drop_n;
	exam_t            r1;
	exam_t            r2;
	scan_t            st1;
	scan_t            st2;
	cst_res_t [MAX_RES-1:0] cand;
	logic [MAX_RES-1:0]     cv;
	cst_bundle_t      b;

	always_comb begin
		cur   = (pos_q > POS_LIM) ? POS_LIM : pos_q;
		ovf_n = ovf_q || (pos_q >= POS_LIM);
		pos_n = (pos_q == POS_SAT) ? POS_SAT : pos_q + END_W'(1);
		hidx  = pos_q - END_W'(1);
		len   = (pos_n > POS_LIM) ? POS_LIM : pos_n;

		r1 = examine(st_q, held_q, ch_s1, hidx);
		if (held_vld_q && !drop_q) begin
			st1    = r1.st;
			drop_n = r1.skip;
		end else begin
			st1    = st_q;
			drop_n = 1'b0;
		end

		// the final byte sees NUL as its successor
		r2  = examine(st1, ch_s1, CH_NUL, cur);
		st2 = drop_n ? st1 : r2.st;

		cand[0] = '{kind: KIND_TOKEN, tstart: r1.estart, tend: r1.eend, ovf: ovf_n};
		cand[1] = '{kind: KIND_TOKEN, tstart: r2.estart, tend: r2.eend, ovf: ovf_n};
		cand[2] = '{kind: KIND_TOKEN, tstart: st2.ostart, tend: len, ovf: ovf_n};
		cand[3] = '{kind: KIND_EOT, tstart: '0, tend: len, ovf: ovf_n};
		cv[0]   = held_vld_q && !drop_q && r1.emit;
		cv[1]   = fin_s1 && !drop_n && r2.emit;
		cv[2]   = fin_s1 && st2.in_tok;
		cv[3]   = fin_s1;

		// pack the results in order
		b     = '0;
		for (int k = 0; k < MAX_RES; k++) begin
			if (cv[k]) begin
				b.res[b.n[1:0]] = cand[k];
				b.n             = b.n + 3'd1;
			end
		end
	end

	assign bnd  = b;
	assign adv  = vld_s1 && (take || b.n == 3'd0);
	assign load = adv && b.n != 3'd0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			held_q     <= '0;
			held_vld_q <= 1'b0;
			drop_q     <= 1'b0;
			st_q       <= '0;
			pos_q      <= '0;
			ovf_q      <= 1'b0;
		end else if (adv) begin
			if (fin_s1) begin
				held_q     <= '0;
				held_vld_q <= 1'b0;
				drop_q     <= 1'b0;
				st_q       <= '0;
				pos_q      <= '0;
				ovf_q      <= 1'b0;
			end else begin
				held_q     <= ch_s1;
				held_vld_q <= 1'b1;
				drop_q     <= drop_n;
				st_q       <= st1;
				pos_q      <= pos_n;
				ovf_q      <= ovf_n;
			end
		end
	end

	`ASSERT_NEXT(a_fin_clears, clk, arst_n, adv && fin_s1, !held_vld_q && pos_q == '0)
	`ASSERT_NOW(a_remark_excl, clk, arst_n, st_q.line, !st_q.block)

endmodule

@@ src/cst_out.sv @@
`include "assert_macros.svh"

module cst_out
	import cst_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	input  logic             load,
	input  cst_bundle_t      bnd,
	output logic             take,
	output logic             tok_valid,
	input  logic             tok_stall,
	output logic             kind,
	output logic [POS_W-1:0] first_pos,
	output logic [END_W-1:0] token_end,
	output logic             overflow,
	output logic             run_last
);

	cst_res_t [MAX_RES-1:0] res_q;
	logic [2:0]             n_q;
	logic [1:0]             rd_q;
	logic                   busy_q;
	logic                   last;
	logic                   pop;
	cst_res_t               cur;

	assign last = ({1'b0, rd_q} == n_q - 3'd1);
	assign pop  = busy_q && !tok_stall;
	assign take = !busy_q || (last && !tok_stall);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			n_q    <= '0;
			rd_q   <= '0;
		end else if (load) begin
			busy_q <= 1'b1;
			n_q    <= bnd.n;
			rd_q   <= '0;
		end else if (pop) begin
			if (last) begin
				busy_q <= 1'b0;
			end else begin
				rd_q <= rd_q + 2'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			res_q <= bnd.res;
		end
	end

	assign cur       = res_q[rd_q];
	assign tok_valid = busy_q;
	assign kind      = cur.kind;
	assign first_pos = cur.tstart;
	assign token_end = cur.tend;
	assign overflow  = cur.ovf;
	assign run_last  = last;

	`ASSERT_NEXT(a_more_follow, clk, arst_n, tok_valid && !tok_stall && !run_last, tok_valid)
	`ASSERT_NOW(a_eot_last, clk, arst_n, tok_valid && kind == KIND_EOT, run_last)
	`ASSERT_NOW(a_tok_span, clk, arst_n, tok_valid && kind == KIND_TOKEN,
		token_end > {1'b0, first_pos})

endmodule

@@ src/comment_skipping_tokenizer.sv @@
// Tokenizer that skips line and block comments, one text byte per word.
// Throughput: one byte per cycle while tok_stall is low; a byte that yields results holds
// the input while the output register hands out earlier ones, one per cycle unless stalled.
// Results caused by a byte pass through the input register, then the result register;
// a byte's tokens close when the next byte comes.
// Reset (arst_n low, asynchronous) clears all scan state and drops pending results.
module comment_skipping_tokenizer
	import cst_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	input  logic             byte_valid,
	output logic             byte_stall,
	input  logic [7:0]       ch,
	input  logic             final_byte,
	output logic             tok_valid,
	input  logic             tok_stall,
	output logic             kind,
	output logic [POS_W-1:0] first_pos,
	output logic [END_W-1:0] token_end,
	output logic             overflow,
	output logic             run_last
);

	logic        vld_s1;
	logic [7:0]  ch_s1;
	logic        fin_s1;
	logic        adv;
	logic        load;
	logic        take;
	cst_bundle_t bnd;

	cst_in_reg u_in (
		.clk        (clk),
		.arst_n     (arst_n),
		.byte_valid (byte_valid),
		.byte_stall (byte_stall),
		.ch         (ch),
		.final_byte (final_byte),
		.adv        (adv),
		.vld_s1     (vld_s1),
		.ch_s1      (ch_s1),
		.fin_s1     (fin_s1)
	);

	cst_core u_core (
		.clk    (clk),
		.arst_n (arst_n),
		.vld_s1 (vld_s1),
		.ch_s1  (ch_s1),
		.fin_s1 (fin_s1),
		.take   (take),
		.adv    (adv),
		.load   (load),
		.bnd    (bnd)
	);

	cst_out u_out (
		.clk       (clk),
		.arst_n    (arst_n),
		.load      (load),
		.bnd       (bnd),
		.take      (take),
		.tok_valid (tok_valid),
		.tok_stall (tok_stall),
		.kind      (kind),
		.first_pos (first_pos),
		.token_end (token_end),
		.overflow  (overflow),
		.run_last  (run_last)
	);

endmodule
